FILE: sv/newreno_congestion_window_assert.svh
// Assertion macros for the congestion window block.
`ifndef NEWRENO_CONGESTION_WINDOW_ASSERT_SVH
`define NEWRENO_CONGESTION_WINDOW_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define NCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define NCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/ncw_pkg.sv
// Package with event codes, register indexes and shared types.
`timescale 1ns / 1ps
package ncw_pkg;
  localparam logic [2:0] ACT_ACK     = 3'd0;
  localparam logic [2:0] ACT_DUP     = 3'd1;
  localparam logic [2:0] ACT_TIMEOUT = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_INIT    = 3'd4;

  localparam logic [1:0] REG_MSS   = 2'd0;
  localparam logic [1:0] REG_IW    = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;
  localparam logic [1:0] REG_REORD = 2'd3;

  localparam logic [31:0] THRESH_RESET = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] acked;
    logic [31:0] una;
    logic [31:0] smax;
    logic [7:0]  dups;
  } ncw_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_FIN, ST_OUT
  } ncw_state_t;
endpackage

FILE: sv/ncw_front.sv
// Input stage and two-entry queue that feeds the event engine.
`timescale 1ns / 1ps
module ncw_front import ncw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ncw_item_t   in_item,
  output logic        q_valid,
  input  logic        q_ready,
  output ncw_item_t   q_item
);
  ncw_item_t  mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= in_item;
  end
endmodule

FILE: sv/ncw_back.sv
// Event engine: state registers, serial divider and result register.
`timescale 1ns / 1ps
module ncw_back import ncw_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  ncw_item_t   q_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_cwnd,
  output logic [31:0] out_ssth,
  output logic        out_rec,
  output logic        busy
);
  logic [15:0] mss_r;
  logic [31:0] iw_r;
  logic [3:0]  shift_r;
  logic [7:0]  reord_r;

  logic [31:0] cwnd_r, cwnd_nxt, ssth_r, ssth_nxt, rpt_r, rpt_nxt;
  logic        rec_r, rec_nxt;
  ncw_state_t  st_r, st_nxt;
  ncw_item_t   it_r;
  logic [31:0] quo_r, rem_r, num_r, quo_nxt, rem_nxt, num_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [39:0] prod_r;
  logic        load, ca;
  logic [32:0] trial;
  logic [31:0] half, floor_t, inc, diff;
  logic [32:0] sum33;
  logic [46:0] cap, sum47;

  assign ca    = (cwnd_r > ssth_r);
  assign load  = (st_r == ST_IDLE) && q_valid;
  assign trial = {rem_r, num_r[31]} - {1'b0, cwnd_r};
  assign half    = (it_r.smax - it_r.una) >> 1;
  assign floor_t = (half > iw_r) ? half : iw_r;
  assign diff    = it_r.una - rpt_r;
  assign cap     = 47'(MAX_WINDOW) << shift_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = (it_r.action == ACT_ACK && !rec_r && ca) ? ST_DIV : ST_FIN;
      ST_DIV:  if (cnt_r == 6'd31) st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (st_r == ST_IDLE);
    out_valid = (st_r == ST_OUT);
    busy      = (st_r != ST_IDLE);
  end

  // Restoring divider on mss*mss (below 2^32) by cwnd, one bit a cycle.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    if (st_r == ST_MUL) begin
      num_nxt = prod_r[31:0];
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = '0;
    end else if (st_r == ST_DIV) begin
      num_nxt = {num_r[30:0], 1'b0};
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], num_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  always_comb begin
    cwnd_nxt = cwnd_r;
    ssth_nxt = ssth_r;
    rec_nxt  = rec_r;
    rpt_nxt  = rpt_r;
    inc      = '0;
    sum33    = '0;
    sum47    = '0;
    if (st_r == ST_FIN) begin
      case (it_r.action)
        ACT_ACK: begin
          if (rec_r) begin
            if (!diff[31]) begin
              cwnd_nxt = ssth_r;
              rec_nxt  = 1'b0;
            end else begin
              sum33    = {1'b0, cwnd_r} + 33'(mss_r);
              cwnd_nxt = sum33[32] ? '1 : sum33[31:0];
            end
          end else begin
            if (ca) inc = (quo_r == '0) ? 32'd1 : quo_r;
            else inc = (it_r.acked < {15'd0, mss_r, 1'b0}) ?
                       it_r.acked : {15'd0, mss_r, 1'b0};
            sum47    = 47'(cwnd_r) + 47'(inc);
            if (cap < sum47) sum47 = cap;
            cwnd_nxt = (sum47 > 47'h0_FFFF_FFFF) ? '1 : sum47[31:0];
          end
        end
        ACT_DUP: begin
          if (it_r.dups >= reord_r && !rec_r) begin
            rpt_nxt  = it_r.smax;
            rec_nxt  = 1'b1;
            ssth_nxt = floor_t;
            sum47    = 47'(floor_t) + 47'(prod_r[23:0]);
            cwnd_nxt = (sum47 > 47'h0_FFFF_FFFF) ? '1 : sum47[31:0];
          end
        end
        ACT_TIMEOUT: begin
          rec_nxt  = 1'b0;
          rpt_nxt  = it_r.smax;
          ssth_nxt = floor_t;
          cwnd_nxt = iw_r;
        end
        ACT_RESTART: begin
          cwnd_nxt = iw_r;
          rec_nxt  = 1'b0;
        end
        ACT_INIT: begin
          cwnd_nxt = iw_r;
          ssth_nxt = THRESH_RESET;
          rec_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      mss_r   <= 16'd1460;
      iw_r    <= 32'd14600;
      shift_r <= 4'd0;
      reord_r <= 8'd3;
      cwnd_r  <= 32'd14600;
      ssth_r  <= THRESH_RESET;
      rec_r   <= 1'b0;
      rpt_r   <= '0;
      cnt_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      cwnd_r <= cwnd_nxt;
      ssth_r <= ssth_nxt;
      rec_r  <= rec_nxt;
      rpt_r  <= rpt_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_MSS:   mss_r   <= cfg_data[15:0];
          REG_IW:    iw_r    <= cfg_data;
          REG_SHIFT: shift_r <= cfg_data[3:0];
          REG_REORD: reord_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Product is mss*mss for avoidance, mss*dups for recovery entry.
  always_ff @(posedge clk) begin
    if (load) it_r <= q_item;
    if (st_r == ST_IDLE && q_valid) begin
      if (q_item.action == ACT_ACK) prod_r <= 40'(mss_r) * 40'(mss_r);
      else prod_r <= 40'(mss_r) * 40'(q_item.dups);
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign out_cwnd = cwnd_r;
  assign out_ssth = ssth_r;
  assign out_rec  = rec_r;
endmodule

FILE: sv/newreno_congestion_window.sv
// Top level of the NewReno congestion window block.
// One event word in, one result word out. A two-entry queue takes words while
// the engine works. Duplicate acks, timeouts, restarts, inits and acks in
// recovery or slow start pass states MUL, FIN and OUT, waiting in OUT for the
// output handshake; a congestion-avoidance ack also runs the 32-step serial
// divider for mss*mss/cwnd between MUL and FIN. The result stays on the
// outputs until taken. Config writes take effect at once, even mid-event.
`timescale 1ns / 1ps
`include "newreno_congestion_window_assert.svh"
module newreno_congestion_window import ncw_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_acked_bytes,
  input  logic [31:0] in_oldest_unacked_seq,
  input  logic [31:0] in_highest_sent_seq,
  input  logic [7:0]  in_dup_ack_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_congestion_window,
  output logic [31:0] out_slow_start_threshold,
  output logic        out_in_recovery,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  ncw_item_t in_item, q_item;
  logic      q_valid, q_ready, busy;

  assign in_item = '{action: in_action, acked: in_acked_bytes,
                     una: in_oldest_unacked_seq, smax: in_highest_sent_seq,
                     dups: in_dup_ack_count};
  assign cfg_ready = 1'b1;

  ncw_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  ncw_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .out_valid, .out_ready,
    .out_cwnd(out_congestion_window), .out_ssth(out_slow_start_threshold),
    .out_rec(out_in_recovery), .busy
  );

  // The engine never takes a queued word while it is busy.
  `NCW_ASSERT_IMP(a_no_take_busy, busy, !q_ready, "engine took word while busy")
  // A stalled result keeps its value.
  `NCW_ASSERT_NXT(a_hold, out_valid && !out_ready, $stable(out_congestion_window), "result moved")
endmodule
